[rtl/core/ic4o4_pkg.sv]
// ----------------------------------------------------------------------------
// ic4o4_pkg
// Shared types of the induced C4 / independent-four check unit: the transaction
// payloads and the command group from the controller to the datapath.
// ----------------------------------------------------------------------------
package ic4o4_pkg;

  localparam int RowWidth = 32;

  typedef struct packed {
    logic [RowWidth-1:0] row_bits;
    logic                last_row;
  } ic4o4_in_t;

  typedef struct packed {
    logic c4_free;
    logic o4_free;
    logic both_free;
  } ic4o4_out_t;

  typedef struct packed {
    logic store;
    logic clear;
    logic w_cap;
    logic b_cap;
    logic c_eval;
    logic post;
  } ic4o4_cmd_t;

endpackage

[rtl/core/ic4o4_ram.sv]
// ----------------------------------------------------------------------------
// ic4o4_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ic4o4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ic4o4_ctrl.sv]
// ----------------------------------------------------------------------------
// ic4o4_ctrl
// Controller: counts loaded rows, sequences the column pass and the walk over
// row pairs, and owns the result handshake.
// ----------------------------------------------------------------------------
module ic4o4_ctrl
  import ic4o4_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_last,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ram_we,
  output logic [$clog2(MAX_VERTICES)-1:0] ram_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0] ram_raddr,
  output logic [$clog2(MAX_VERTICES)-1:0] v_idx,
  output logic [$clog2(MAX_VERTICES)-1:0] b_idx,
  output logic [$clog2(MAX_VERTICES)-1:0] c_idx,
  output ic4o4_cmd_t                      cmd
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WRD  = 3'd1;
  localparam logic [2:0] S_WCAP = 3'd2;
  localparam logic [2:0] S_BRD  = 3'd3;
  localparam logic [2:0] S_BCAP = 3'd4;
  localparam logic [2:0] S_CRD  = 3'd5;
  localparam logic [2:0] S_CEV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] rows_r, rows_nxt;
  logic [IW-1:0] v_r, v_nxt;
  logic [IW-1:0] b_r, b_nxt;
  logic [IW-1:0] c_r, c_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_fire;
  logic          room;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign room      = (rows_r < CW'(MAX_VERTICES));
  assign ram_we    = in_fire && room;
  assign ram_waddr = rows_r[IW-1:0];
  assign ram_raddr = (state_r == S_BRD) ? b_r : c_r;
  assign v_idx     = v_r;
  assign b_idx     = b_r;
  assign c_idx     = c_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    v_nxt         = v_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.store     = ram_we;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (room) begin
            rows_nxt = rows_r + CW'(1);
          end
          if (in_last) begin
            cmd.clear = 1'b1;
            v_nxt     = room ? rows_r[IW-1:0] : IW'(MAX_VERTICES - 1);
            rows_nxt  = '0;
            c_nxt     = '0;
            state_nxt = S_WRD;
          end
        end
      end
      S_WRD: begin
        state_nxt = S_WCAP;
      end
      S_WCAP: begin
        cmd.w_cap = 1'b1;
        if (c_r == v_r) begin
          c_nxt     = '0;
          b_nxt     = '0;
          state_nxt = S_BRD;
        end else begin
          c_nxt     = c_r + IW'(1);
          state_nxt = S_WRD;
        end
      end
      S_BRD: begin
        state_nxt = S_BCAP;
      end
      S_BCAP: begin
        cmd.b_cap = 1'b1;
        c_nxt     = '0;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        state_nxt = S_CEV;
      end
      S_CEV: begin
        cmd.c_eval = 1'b1;
        if (c_r == v_r) begin
          if (b_r == v_r) begin
            state_nxt = S_FIN;
          end else begin
            b_nxt     = b_r + IW'(1);
            state_nxt = S_BRD;
          end
        end else begin
          c_nxt     = c_r + IW'(1);
          state_nxt = S_CRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      v_r         <= '0;
      b_r         <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      v_r         <= v_nxt;
      b_r         <= b_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/ic4o4_dpath.sv]
// ----------------------------------------------------------------------------
// ic4o4_dpath
// Datapath: holds the newest row, the column of the newest vertex and the
// current outer row, tests each inner row against them and keeps the hits.
// ----------------------------------------------------------------------------
module ic4o4_dpath
  import ic4o4_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ic4o4_cmd_t                      cmd,
  input  logic [RowWidth-1:0]             in_row,
  input  logic [RowWidth-1:0]             rd_row,
  input  logic [$clog2(MAX_VERTICES)-1:0] v_idx,
  input  logic [$clog2(MAX_VERTICES)-1:0] b_idx,
  input  logic [$clog2(MAX_VERTICES)-1:0] c_idx,
  output ic4o4_out_t                      out_data
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int VW = MAX_VERTICES;

  logic [RowWidth-1:0]    vrow_r;
  logic [VW-1:0]          w_r, w_nxt;
  logic [VW-1:0]          rowb_r;
  logic                   c4_hit_r, c4_hit_nxt;
  logic                   o4_hit_r, o4_hit_nxt;
  ic4o4_out_t             out_r;
  logic [VW+RowWidth-1:0] rd_wide;
  logic [VW+RowWidth-1:0] v_wide;
  logic [VW-1:0]          rd_ext;
  logic [VW-1:0]          le_v;
  logic [VW-1:0]          below_b;
  logic [VW-1:0]          nv;
  logic [VW-1:0]          rowc;
  logic                   c4_cond;
  logic                   o4_cond;

  assign rd_wide = {{VW{1'b0}}, rd_row};
  assign v_wide  = {{VW{1'b0}}, vrow_r};
  assign rd_ext  = rd_wide[VW-1:0];

  always_comb begin
    for (int i = 0; i < VW; i++) begin
      le_v[i]    = (IW'(i) <= v_idx);
      below_b[i] = (IW'(i) < b_idx);
    end
  end

  assign nv   = v_wide[VW-1:0] & le_v;
  assign rowc = rd_ext & le_v;

  assign c4_cond = nv[b_idx] && rowb_r[c_idx] && (c_idx != v_idx) && !rowc[v_idx]
                   && (|(nv & rowc & ~rowb_r & below_b));
  assign o4_cond = (b_idx < v_idx) && !w_r[b_idx] && (c_idx > b_idx) && (c_idx < v_idx)
                   && !rowc[b_idx] && !rowc[v_idx]
                   && (|(~w_r & ~rowb_r & ~rowc & below_b));

  always_comb begin
    w_nxt      = w_r;
    c4_hit_nxt = c4_hit_r;
    o4_hit_nxt = o4_hit_r;
    if (cmd.w_cap) begin
      w_nxt[c_idx] = rd_ext[v_idx];
    end
    if (cmd.clear) begin
      c4_hit_nxt = 1'b0;
      o4_hit_nxt = 1'b0;
    end else if (cmd.c_eval) begin
      c4_hit_nxt = c4_hit_r || c4_cond;
      o4_hit_nxt = o4_hit_r || o4_cond;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_hit_r <= 1'b0;
      o4_hit_r <= 1'b0;
    end else begin
      c4_hit_r <= c4_hit_nxt;
      o4_hit_r <= o4_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (cmd.store) begin
      vrow_r <= in_row;
    end
    if (cmd.b_cap) begin
      rowb_r <= rd_ext & le_v;
    end
    if (cmd.post) begin
      out_r.c4_free   <= !c4_hit_r;
      out_r.o4_free   <= !o4_hit_r;
      out_r.both_free <= !c4_hit_r && !o4_hit_r;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/core/induced_c4_o4_check_unit.sv]
// ----------------------------------------------------------------------------
// induced_c4_o4_check_unit
// Induced C4 (four-vertex hole) and independent-four test for the newest vertex of a graph.
//
// Adjacency rows load at one transaction per cycle into a row memory while the
// unit is idle. The transaction marked as the last row closes the graph; the
// unit then reads the column of the newest vertex (n reads) and walks every
// ordered pair of stored rows through the single read port (n + n * n reads)
// before the result is posted. Rows of the next graph are not taken during
// that search, but the finished result waits in its output register while
// the next graph loads.
// ----------------------------------------------------------------------------
module induced_c4_o4_check_unit
  import ic4o4_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ic4o4_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ic4o4_out_t out_data
);

  localparam int IW = $clog2(MAX_VERTICES);

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [IW-1:0]       ram_raddr;
  logic [RowWidth-1:0] ram_rdata;
  logic [IW-1:0]       v_idx;
  logic [IW-1:0]       b_idx;
  logic [IW-1:0]       c_idx;
  ic4o4_cmd_t          cmd;

  ic4o4_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_row),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .v_idx     (v_idx),
    .b_idx     (b_idx),
    .c_idx     (c_idx),
    .cmd       (cmd)
  );

  ic4o4_ram #(
    .WIDTH(RowWidth),
    .DEPTH(MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.row_bits),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ic4o4_dpath #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_row   (in_data.row_bits),
    .rd_row   (ram_rdata),
    .v_idx    (v_idx),
    .b_idx    (b_idx),
    .c_idx    (c_idx),
    .out_data (out_data)
  );

endmodule
